/* src/bcu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcu_pkg
// Shared constants, register indexes and the calibration struct.
// ----------------------------------------------------------------------------
package bcu_pkg;

    localparam int CfgIdxW = 3;

    // Side data width for each divider, sized for the temperature path: x1, sign, zero flag, raw pressure.
    localparam int DivSideW = 32 + 1 + 1 + 19;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_AC1_AC2 = 3'd0,
        CFG_AC3_AC4 = 3'd1,
        CFG_AC5_AC6 = 3'd2,
        CFG_B1_B2   = 3'd3,
        CFG_MC_MD   = 3'd4,
        CFG_OSS     = 3'd5
    } cfg_idx_t;

    // Calibration words, already split and extended to 32 bits, plus the 2-bit oss.
    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
        logic [1:0]  oss;
    } cal_t;

    localparam logic [31:0] B6Offset  = 32'd4000;
    localparam logic [31:0] B7Scale   = 32'd50000;
    localparam logic [31:0] C3038     = 32'd3038;
    localparam logic [31:0] CM7357    = 32'hFFFF_E343;
    localparam logic [31:0] C3791     = 32'd3791;
    localparam logic [31:0] TempBase  = 32'd2732;
    localparam logic [31:0] X3Offset  = 32'd32768;

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
        return 32'($signed(v) >>> s);
    endfunction

endpackage

/* src/bcu_udiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcu_udiv
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
// Side data travels along in lock step; the pipe advances on en.
// ----------------------------------------------------------------------------
module bcu_udiv (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [31:0]                  num,
    input  logic [31:0]                  den,
    input  logic [bcu_pkg::DivSideW-1:0] side_in,
    output logic [31:0]                  quo,
    output logic [bcu_pkg::DivSideW-1:0] side_out
);
    import bcu_pkg::*;

    logic [31:0] rem_reg  [32];
    logic [31:0] n_reg    [32];
    logic [31:0] d_reg    [32];
    logic [DivSideW-1:0] s_reg [32];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 32; i++) begin
                logic [32:0] trial;
                logic [31:0] r_in, n_in, d_in;
                r_in = (i == 0) ? 32'd0 : rem_reg[i-1];
                n_in = (i == 0) ? num : n_reg[i-1];
                d_in = (i == 0) ? den : d_reg[i-1];
                trial = {r_in, n_in[31]} - {1'b0, d_in};
                if (!trial[32]) begin
                    rem_reg[i] <= trial[31:0];
                    n_reg[i]   <= {n_in[30:0], 1'b1};
                end else begin
                    rem_reg[i] <= {r_in[30:0], n_in[31]};
                    n_reg[i]   <= {n_in[30:0], 1'b0};
                end
                d_reg[i] <= d_in;
                s_reg[i] <= (i == 0) ? side_in : s_reg[i-1];
            end
        end
    end

    assign quo      = n_reg[31];
    assign side_out = s_reg[31];
endmodule

/* src/bcu_temp_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcu_temp_stage
// Temperature path: x1, divisor, signed divide mc*2048/(x1+md), b5.
// ----------------------------------------------------------------------------
module bcu_temp_stage (
    input  logic          aclk,
    input  logic          en,
    input  bcu_pkg::cal_t cal,
    input  logic [15:0]   raw_t,
    input  logic [18:0]   raw_p,
    output logic [31:0]   b5,
    output logic          fault,
    output logic [18:0]   raw_p_out
);
    import bcu_pkg::*;

    logic [31:0] diff_reg, x1_reg, x1b_reg, div_reg, mn_reg, md_reg;
    logic [18:0] p1_reg, p2_reg;
    logic        neg_reg;
    logic [31:0] quo;
    logic [DivSideW-1:0] side_out;

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= 32'({16'd0, raw_t}) - cal.ac6;
            p1_reg   <= raw_p;
            x1_reg   <= asr32(diff_reg * cal.ac5, 15);
            p2_reg   <= p1_reg;
        end
    end

    logic [31:0] dsum, mcn;
    assign dsum = x1_reg + cal.md;
    assign mcn  = cal.mc << 11;
    logic [18:0] p3_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg <= dsum;
            mn_reg  <= mcn[31] ? 32'd0 - mcn : mcn;
            md_reg  <= dsum[31] ? 32'd0 - dsum : dsum;
            neg_reg <= mcn[31] ^ dsum[31];
            x1b_reg <= x1_reg;
            p3_reg  <= p2_reg;
        end
    end

    bcu_udiv u_div (
        .aclk    (aclk),
        .en      (en),
        .num     (mn_reg),
        .den     (md_reg),
        .side_in ({x1b_reg, neg_reg, div_reg == 32'd0, p3_reg}),
        .quo     (quo),
        .side_out(side_out)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            b5        <= side_out[52:21] + (side_out[20] ? 32'd0 - quo : quo);
            fault     <= side_out[19];
            raw_p_out <= side_out[18:0];
        end
    end
endmodule

/* src/bcu_press_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcu_press_stage
// Pressure path from b5: b3, b4, b7, unsigned divide, final correction; also the temperature.
// ----------------------------------------------------------------------------
module bcu_press_stage (
    input  logic          aclk,
    input  logic          en,
    input  bcu_pkg::cal_t cal,
    input  logic [31:0]   b5,
    input  logic          fault_in,
    input  logic [18:0]   raw_p,
    output logic [15:0]   temp,
    output logic [31:0]   pres,
    output logic          fault
);
    import bcu_pkg::*;

    logic [15:0] t1, t2, t3, t4, t5, t6, t7;
    logic        f1, f2, f3, f4, f5, f6, f7;
    logic [18:0] p1, p2, p3, p4, p5;
    logic [31:0] b6_1, b6_2, sq_2, m1_3, m2_3, m3_3, m4_3;
    logic [31:0] x3a_4, x3b_4, ac1x4;
    logic [31:0] b3_5, b4_5, b4_6, b7_6, num_6;
    logic        lo_6;

    logic [31:0] b5q;
    assign b5q = (b5[31] ? 32'd0 - ((32'd0 - b5) >> 4) : (b5 >> 4));
    assign ac1x4 = cal.ac1 << 2;

    logic [31:0] b3s, b3q, x3c;
    assign b3s = ((ac1x4 + x3a_4) << cal.oss) + 32'd2;
    assign b3q = b3s[31] ? 32'd0 - ((32'd0 - b3s) >> 2) : (b3s >> 2);
    assign x3c = asr32(x3b_4 + 32'd2, 2);

    always_ff @(posedge aclk) begin
        if (en) begin
            t1 <= 16'(TempBase + b5q); f1 <= fault_in; p1 <= raw_p;
            b6_1 <= b5 - B6Offset;
            t2 <= t1; f2 <= f1; p2 <= p1; b6_2 <= b6_1;
            sq_2 <= asr32(b6_1 * b6_1, 12);
            t3 <= t2; f3 <= f2; p3 <= p2;
            m1_3 <= asr32(cal.b2 * sq_2, 11);
            m2_3 <= asr32(cal.ac2 * b6_2, 11);
            m3_3 <= asr32(cal.ac3 * b6_2, 13);
            m4_3 <= asr32(cal.b1 * sq_2, 16);
            t4 <= t3; f4 <= f3; p4 <= p3;
            x3a_4 <= m1_3 + m2_3;
            x3b_4 <= m3_3 + m4_3;
            t5 <= t4; f5 <= f4; p5 <= p4;
            b3_5 <= b3q;
            b4_5 <= (cal.ac4 * (x3c + X3Offset)) >> 15;
            t6 <= t5; b4_6 <= b4_5;
            f6 <= f5 | (b4_5 == 32'd0);
            b7_6 <= (32'({13'd0, p5}) - b3_5) * (B7Scale >> cal.oss);
        end
    end

    assign lo_6  = ~b7_6[31];
    assign num_6 = lo_6 ? (b7_6 << 1) : b7_6;

    logic [31:0] q;
    logic [DivSideW-1:0] so;
    bcu_udiv u_div (
        .aclk(aclk), .en(en), .num(num_6), .den(b4_6),
        .side_in({35'd0, t6, f6, lo_6}), .quo(q), .side_out(so)
    );

    logic [31:0] pq_8, x1_9, x2_9, p_9, x1_10, p_10;
    always_ff @(posedge aclk) begin
        if (en) begin
            pq_8 <= so[0] ? q : (q << 1);
            t7 <= so[17:2]; f7 <= so[1];
            x1_9 <= asr32(pq_8, 8) * asr32(pq_8, 8);
            x2_9 <= asr32(CM7357 * pq_8, 16);
            p_9  <= pq_8;
            x1_10 <= asr32(x1_9 * C3038, 16);
            p_10 <= p_9;
        end
    end

    // The flag and temperature delay line matches the two correction stages
    // between the divider output and the final sum.
    logic [15:0] t8, t9;
    logic        f8, f9;
    logic [31:0] x2_10;
    always_ff @(posedge aclk) begin
        if (en) begin
            t8 <= t7; f8 <= f7; t9 <= t8; f9 <= f8;
            x2_10 <= x2_9;
            pres  <= f9 ? 32'd0 : p_10 + asr32(x1_10 + x2_10 + C3791, 4);
            temp  <= f9 ? 16'd0 : t9;
            fault <= f9;
        end
    end
endmodule

/* src/barometer_compensation_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometer_compensation_unit
// Raw temperature and pressure to deci-kelvin and pascals.
// ----------------------------------------------------------------------------
// One item per cycle is accepted while the pipeline advances; the pipeline is 78
// register stages deep. The depth is set by two 32-stage pipelined dividers
// (temperature and pressure) plus fourteen multiply and add stages around them.
// The whole pipeline advances when the output register is empty or being taken,
// so an item enters in every cycle while m_axis_tready stays high.
// Configuration must be written while idle.
module barometer_compensation_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] raw_temperature, [34:16] raw_pressure
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] temperature_decikelvin, [47:16] pressure_pascal
    output logic [47:0] m_axis_tdata,
    // [0] divide_fault
    output logic        m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import bcu_pkg::*;

    localparam int Depth = 78;

    logic [31:0] r0_reg, r1_reg, r2_reg, r3_reg, r4_reg;
    logic [1:0]  oss_reg;
    cal_t        cal;
    logic [Depth-1:0] vld_reg;
    logic        en;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0_reg <= '0; r1_reg <= '0; r2_reg <= '0; r3_reg <= '0; r4_reg <= '0;
            oss_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_AC1_AC2: r0_reg <= cfg_data;
                CFG_AC3_AC4: r1_reg <= cfg_data;
                CFG_AC5_AC6: r2_reg <= cfg_data;
                CFG_B1_B2:   r3_reg <= cfg_data;
                CFG_MC_MD:   r4_reg <= cfg_data;
                CFG_OSS:     oss_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cal.ac1 = 32'($signed(r0_reg[31:16]));
        cal.ac2 = 32'($signed(r0_reg[15:0]));
        cal.ac3 = 32'($signed(r1_reg[31:16]));
        cal.ac4 = {16'd0, r1_reg[15:0]};
        cal.ac5 = {16'd0, r2_reg[31:16]};
        cal.ac6 = {16'd0, r2_reg[15:0]};
        cal.b1  = 32'($signed(r3_reg[31:16]));
        cal.b2  = 32'($signed(r3_reg[15:0]));
        cal.mc  = 32'($signed(r4_reg[31:16]));
        cal.md  = 32'($signed(r4_reg[15:0]));
        cal.oss = oss_reg;
    end

    assign m_axis_tvalid = vld_reg[Depth-1];
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[Depth-2:0], s_axis_tvalid};
    end

    logic [31:0] b5;
    logic        tf;
    logic [18:0] rp;
    bcu_temp_stage u_temp (
        .aclk(aclk), .en(en), .cal(cal),
        .raw_t(s_axis_tdata[15:0]), .raw_p(s_axis_tdata[34:16]),
        .b5(b5), .fault(tf), .raw_p_out(rp)
    );

    logic [15:0] temp;
    logic [31:0] pres;
    logic        fault;
    bcu_press_stage u_press (
        .aclk(aclk), .en(en), .cal(cal), .b5(b5), .fault_in(tf), .raw_p(rp),
        .temp(temp), .pres(pres), .fault(fault)
    );

    assign m_axis_tdata = {pres, temp};
    assign m_axis_tuser = fault;
endmodule

/* src/bcu_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcu_checker
// Port-level checks on the result stream and the input ready.
// ----------------------------------------------------------------------------
module bcu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 48'd0)
        else $error("fault result not zero");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
endmodule

bind barometer_compensation_unit bcu_checker u_chk (.*);

/* sim/tb_barometer_compensation_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barometer_compensation_unit
// Streams raw temperature/pressure pairs through the compensation unit under
// several calibration sets and checks every result against a local model.
// ----------------------------------------------------------------------------
module tb_barometer_compensation_unit;
    import bcu_pkg::*;

    typedef struct packed {
        logic [15:0] temp_dk;
        logic [31:0] press_pa;
        logic        fault;
    } comp_result_t;

    localparam int StallLimit = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic [31:0] cal_words [0:4];
    logic [1:0]  oss_reg;
    comp_result_t expected_results [$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          quiet_cycles = 0;

    barometer_compensation_unit dut (.*);

    always #4 aclk = ~aclk;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] v, input int s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] quot_trunc(input logic [31:0] n, input logic [31:0] d);
        logic [31:0] mn, mdv, q;
        mn  = n[31] ? -n : n;
        mdv = d[31] ? -d : d;
        q   = mn / mdv;
        return (n[31] != d[31]) ? -q : q;
    endfunction

    function automatic comp_result_t compensate(input logic [15:0] ut_in,
                                                input logic [18:0] up_in);
        comp_result_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, dv, temp;
        int oss;
        ac1 = sx16(cal_words[CFG_AC1_AC2][31:16]);
        ac2 = sx16(cal_words[CFG_AC1_AC2][15:0]);
        ac3 = sx16(cal_words[CFG_AC3_AC4][31:16]);
        ac4 = {16'd0, cal_words[CFG_AC3_AC4][15:0]};
        ac5 = {16'd0, cal_words[CFG_AC5_AC6][31:16]};
        ac6 = {16'd0, cal_words[CFG_AC5_AC6][15:0]};
        b1  = sx16(cal_words[CFG_B1_B2][31:16]);
        b2  = sx16(cal_words[CFG_B1_B2][15:0]);
        mc  = sx16(cal_words[CFG_MC_MD][31:16]);
        md  = sx16(cal_words[CFG_MC_MD][15:0]);
        oss = oss_reg;
        r = '{temp_dk: '0, press_pa: '0, fault: 1'b1};
        x1 = sra(({16'd0, ut_in} - ac6) * ac5, 15);
        dv = x1 + md;
        if (dv == 0) return r;
        x2 = quot_trunc(mc * 32'd2048, dv);
        b5 = x1 + x2;
        temp = (32'd2732 + quot_trunc(b5, 32'd16)) & 32'hFFFF;
        b6 = b5 - 32'd4000;
        sq = sra(b6 * b6, 12);
        x1 = sra(b2 * sq, 11);
        x2 = sra(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = quot_trunc(((ac1 * 32'd4 + x3) << oss) + 32'd2, 32'd4);
        x1 = sra(ac3 * b6, 13);
        x2 = sra(b1 * sq, 16);
        x3 = sra(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) return r;
        b7 = ({13'd0, up_in} - b3) * (32'd50000 >> oss);
        if (!b7[31]) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = sra(p, 8) * sra(p, 8);
        x1 = sra(x1 * 32'd3038, 16);
        x2 = sra(-32'd7357 * p, 16);
        p = p + sra(x1 + x2 + 32'd3791, 4);
        r.temp_dk = temp[15:0];
        r.press_pa = p;
        r.fault = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%08h expected 0x%08h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Receiver stalls and the result check.
    always @(posedge aclk) begin
        comp_result_t w;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item", 32'(m_axis_tdata[15:0]), '0);
                end else begin
                    w = expected_results.pop_front();
                    if (m_axis_tdata[15:0] !== w.temp_dk)
                        report_mismatch("temperature", 32'(m_axis_tdata[15:0]), 32'(w.temp_dk));
                    if (m_axis_tdata[47:16] !== w.press_pa)
                        report_mismatch("pressure", m_axis_tdata[47:16], w.press_pa);
                    if (m_axis_tuser !== w.fault)
                        report_mismatch("divide fault", 32'(m_axis_tuser), 32'(w.fault));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Valid stays high after the accepting edge so that items can follow back
    // to back; the idle loop and drain take it low.
    task automatic send_reading(input logic [15:0] ut_in, input logic [18:0] up_in);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, up_in, ut_in};
        expected_results.push_back(compensate(ut_in, up_in));
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_OSS) oss_reg = val[1:0];
        else cal_words[idx] = val;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic load_calibration(input logic [31:0] w0, w1, w2, w3, w4,
                                    input logic [1:0] oss);
        drain();
        write_reg(CFG_AC1_AC2, w0);
        write_reg(CFG_AC3_AC4, w1);
        write_reg(CFG_AC5_AC6, w2);
        write_reg(CFG_B1_B2, w3);
        write_reg(CFG_MC_MD, w4);
        write_reg(CFG_OSS, {30'd0, oss});
        cfg_valid <= 1'b0;
    endtask

    // Typical datasheet-like calibration set.
    task automatic load_typical(input logic [1:0] oss);
        load_calibration({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
                         {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                         {-16'sd8711, 16'd2868}, oss);
    endtask

    task automatic test_directed;
        load_typical(2'd0);
        send_reading(16'd27898, 19'd23843);
        send_reading(16'd0, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
        send_reading(16'd0, 19'h7FFFF);
        send_reading(16'hFFFF, 19'd0);
        send_reading(16'h5555, 19'h2AAAA);
        send_reading(16'hAAAA, 19'h55555);
        load_typical(2'd3);
        send_reading(16'd27898, 19'd190744);
        send_reading(16'hFFFF, 19'h7FFFF);
        // Zero temperature divisor: ac5 = 0 makes x1 zero, md = 0.
        load_calibration({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
                         {16'd0, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd0}, 2'd1);
        send_reading(16'd27898, 19'd23843);
        // Zero pressure divisor: ac4 = 0.
        load_calibration({16'd408, -16'sd72}, {-16'sd14383, 16'd0},
                         {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                         {-16'sd8711, 16'd2868}, 2'd2);
        send_reading(16'd27898, 19'd23843);
        // Extreme calibration words, both signs.
        load_calibration(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'h7FFF_7FFF, 2'd3);
        send_reading(16'd0, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
        load_calibration(32'h8000_8000, 32'h8000_0001, 32'h0001_0000,
                         32'h8000_7FFF, 32'h8000_8000, 2'd0);
        send_reading(16'd0, 19'h7FFFF);
        send_reading(16'hFFFF, 19'd0);
    endtask

    task automatic test_random(input int count, input bit wild);
        logic [31:0] w [0:4];
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                if (wild) begin
                    foreach (w[k]) w[k] = $urandom;
                    // Sometimes force a zero divisor path.
                    if ($urandom_range(3) == 0) w[1][15:0] = 16'd0;
                    load_calibration(w[0], w[1], w[2], w[3], w[4], 2'($urandom));
                end else begin
                    load_typical(2'($urandom));
                end
            end
            send_reading(16'($urandom), 19'($urandom));
        end
    endtask

    initial begin
        foreach (cal_words[k]) cal_words[k] = '0;
        oss_reg = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 29;
        recv_idle_pct = 50;
        test_directed();
        test_random(400, 1'b0);
        test_random(300, 1'b1);
        send_idle_pct = 50;
        recv_idle_pct = 29;
        test_random(300, 1'b0);
        test_random(300, 1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(300, 1'b0);
        test_random(300, 1'b1);
        drain();
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
